[rtl/adct_pkg.sv]
// Shared types, constants and kernel functions of the 8x8 approximate DCT.
// Used by adct_front, adct_queue, adct_back and approx_dct_8x8_forward.
// No dependencies.
package adct_pkg;

  // One input sample, one row of samples, one row of row-transform results
  typedef logic signed [8:0]  smp_t;
  typedef logic [7:0][8:0]    row_smp_t;
  typedef logic [7:0][12:0]   row_res_t;
  typedef logic [7:0][15:0]   acc_row_t;

  // Row request from the front end to the queue
  typedef struct packed {
    logic     push;
    row_smp_t data;
  } row_req_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACC,
    BK_EMIT
  } back_state_t;

  // Kernel sign pattern: bit r of entry u marks an added / subtracted input
  localparam logic [7:0] KPOS [8] = '{8'hFF, 8'h07, 8'h81, 8'h31,
                                      8'h99, 8'h49, 8'h24, 8'h54};
  localparam logic [7:0] KNEG [8] = '{8'h00, 8'hE0, 8'h18, 8'h8C,
                                      8'h66, 8'h92, 8'h42, 8'h2A};

  // Apply the kernel sign of output u, input r to v
  function automatic logic signed [15:0] ksel(logic [2:0] u, logic [2:0] r,
                                              logic signed [15:0] v);
    logic signed [15:0] res;
    if (KPOS[u][r]) begin
      res = v;
    end else if (KNEG[u][r]) begin
      res = -v;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // Full eight-point kernel over one row of samples
  function automatic row_res_t row_kernel(row_smp_t x);
    logic signed [15:0] sum;
    row_res_t y;
    for (int u = 0; u < 8; u++) begin
      sum = '0;
      for (int r = 0; r < 8; r++) begin
        sum = sum + ksel(3'(u), 3'(r), {{7{x[r][8]}}, x[r]});
      end
      y[u] = sum[12:0];
    end
    return y;
  endfunction

endpackage

[rtl/approx_dct_8x8_forward.sv]
// Top level of the 8x8 multiplier-free approximate forward DCT.
// Depends on adct_pkg, adct_front, adct_queue and adct_back.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------------
//   input    | start / busy     | in_sample (9b signed)
//   result   | out_valid strobe | out_coefficient (16b signed), out_last_of_block
//
// The front end takes one sample per cycle and stalls (busy) only on the last
// sample of a row while the row queue is full. For each row the back end pops it
// and runs the row kernel, then 8 ring accumulation steps; after the eighth row
// it emits the block's 64 coefficients before it takes the next row.
// Results appear one per cycle and cannot be held off.
// Reset (rst_n low, synchronous) empties the queue and restarts at row 0.
module approx_dct_8x8_forward #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [8:0]  in_sample,
  output logic               out_valid,
  output logic signed [15:0] out_coefficient,
  output logic               out_last_of_block
);

  adct_pkg::row_req_t req;
  adct_pkg::q_stat_t  q_stat;
  adct_pkg::row_smp_t head;
  logic               pop;

  // Collect rows
  adct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_sample (in_sample),
    .q_stat    (q_stat),
    .busy      (busy),
    .req       (req)
  );

  // Decouple front and back
  adct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Transform and emit
  adct_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_coefficient   (out_coefficient),
    .out_last_of_block (out_last_of_block)
  );

endmodule

[rtl/adct_front.sv]
// Front end: collects samples into rows of eight and requests a queue push.
// Depends on adct_pkg.
module adct_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  adct_pkg::smp_t      in_sample,
  input  adct_pkg::q_stat_t   q_stat,
  output logic                busy,
  output adct_pkg::row_req_t  req
);

  logic [2:0]        col_r;
  adct_pkg::row_smp_t rowbuf_r;
  logic              accept;

  // Stall only the last sample of a row while the queue is full
  assign busy   = (col_r == 3'd7) && q_stat.full;
  assign accept = start && !busy;

  // Hand the completed row to the queue
  always_comb begin
    req.data    = rowbuf_r;
    req.data[7] = in_sample;
    req.push    = accept && (col_r == 3'd7);
  end

  // Advance the column position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (accept) begin
      col_r <= col_r + 3'd1;
    end
  end

  // Hold samples of the current row
  always_ff @(posedge clk) begin
    if (accept) begin
      rowbuf_r[col_r] <= in_sample;
    end
  end

endmodule

[rtl/adct_queue.sv]
// Short row queue between the front and back ends.
// Depends on adct_pkg.
module adct_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  adct_pkg::row_req_t  req,
  input  logic                pop,
  output adct_pkg::row_smp_t  head,
  output adct_pkg::q_stat_t   q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  adct_pkg::row_smp_t mem_r [DEPTH];
  logic [PW-1:0]      wptr_r;
  logic [PW-1:0]      rptr_r;
  logic [CW-1:0]      cnt_r;

  assign head         = mem_r[rptr_r];
  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (req.push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (req.push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !req.push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Store pushed rows
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem_r[wptr_r] <= req.data;
    end
  end

endmodule

[rtl/adct_back.sv]
// Back end: row kernel, column accumulation in a rotating ring, coefficient emit.
// Depends on adct_pkg.
module adct_back (
  input  logic                clk,
  input  logic                rst_n,
  input  adct_pkg::row_smp_t  head,
  input  adct_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  output logic signed [15:0]  out_coefficient,
  output logic                out_last_of_block
);

  adct_pkg::back_state_t state_r, state_nxt;
  logic [2:0]            row_r;
  logic [2:0]            u_r;
  logic [5:0]            ecnt_r;
  adct_pkg::row_res_t    rres_r;
  adct_pkg::acc_row_t    ring_r [8];
  adct_pkg::acc_row_t    acc_new;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      adct_pkg::BK_IDLE: begin
        if (!q_stat.empty) state_nxt = adct_pkg::BK_ACC;
      end
      adct_pkg::BK_ACC: begin
        if (u_r == 3'd7) begin
          state_nxt = (row_r == 3'd7) ? adct_pkg::BK_EMIT : adct_pkg::BK_IDLE;
        end
      end
      adct_pkg::BK_EMIT: begin
        if (ecnt_r == 6'd63) state_nxt = adct_pkg::BK_IDLE;
      end
      default: state_nxt = adct_pkg::BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop               = (state_r == adct_pkg::BK_IDLE) && !q_stat.empty;
    out_valid         = (state_r == adct_pkg::BK_EMIT);
    out_coefficient   = ring_r[0][ecnt_r[2:0]];
    out_last_of_block = (state_r == adct_pkg::BK_EMIT) && (ecnt_r == 6'd63);
  end

  // Add this row's share into output row u of every column
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      acc_new[c] = adct_pkg::ksel(u_r, row_r, {{3{rres_r[c][12]}}, rres_r[c]});
      if (row_r != 3'd0) begin
        acc_new[c] = ring_r[0][c] + acc_new[c];
      end
    end
  end

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adct_pkg::BK_IDLE;
      row_r   <= '0;
      u_r     <= '0;
      ecnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == adct_pkg::BK_ACC) begin
        u_r <= u_r + 3'd1;
        if (u_r == 3'd7) row_r <= row_r + 3'd1;
      end
      if (state_r == adct_pkg::BK_EMIT) begin
        ecnt_r <= ecnt_r + 6'd1;
      end
    end
  end

  // Transform the popped row
  always_ff @(posedge clk) begin
    if (pop) begin
      rres_r <= adct_pkg::row_kernel(head);
    end
  end

  // Rotate the accumulator ring: update on accumulate, step per emitted row
  always_ff @(posedge clk) begin
    if (state_r == adct_pkg::BK_ACC) begin
      for (int i = 0; i < 7; i++) ring_r[i] <= ring_r[i+1];
      ring_r[7] <= acc_new;
    end else if (state_r == adct_pkg::BK_EMIT && ecnt_r[2:0] == 3'd7) begin
      for (int i = 0; i < 7; i++) ring_r[i] <= ring_r[i+1];
      ring_r[7] <= ring_r[0];
    end
  end

endmodule
